FILE: rtl/tgr_pkg.sv
// tgr_pkg: constants, types and codes of the text glyph renderer
// used by the channel interfaces and the top level; depends on nothing

package tgr_pkg;

   localparam int GLYPH_ROWS  = 16;
   localparam int GLYPH_COUNT = 256;
   localparam int GLYPH_WIDTH = 8;
   localparam int STORE_DEPTH = GLYPH_ROWS * GLYPH_COUNT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int ROW_W       = $clog2(GLYPH_ROWS);
   localparam int CODE_W      = $clog2(GLYPH_COUNT);

   localparam int COORD_W     = 12;
   localparam int CMD_W       = 2;
   localparam int BYTE_W      = 8;
   localparam int COLOR_W     = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 2;

   localparam logic [CSR_ADDR_W-1:0] LINE_WIDTH_ADDR = '0;

   localparam logic [COORD_W-1:0] Y_LIMIT = COORD_W'((1 << COORD_W) - GLYPH_ROWS);
   localparam logic [COORD_W-1:0] LINE_WIDTH_RESET = COORD_W'(1024);

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CURSOR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PRINT  = 2'd2;

   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [BYTE_W-1:0] CH_RETURN  = 8'd13;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COLOR_W-1:0] color;
      logic               last;
   } row_meta_type;

endpackage

FILE: rtl/tgr_if.sv
// tgr_req_if and tgr_rsp_if: valid/ready channels for command and row words
// depends on tgr_pkg

interface tgr_req_if;
   import tgr_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [COORD_W-1:0] font_index;
   logic [BYTE_W-1:0]  font_byte;
   logic [COORD_W-1:0] start_x;
   logic [COORD_W-1:0] start_y;
   logic [BYTE_W-1:0]  char_code;
   logic [COLOR_W-1:0] color;

   modport source (output valid, cmd, font_index, font_byte, start_x, start_y,
                   char_code, color, input ready);
   modport sink   (input valid, cmd, font_index, font_byte, start_x, start_y,
                   char_code, color, output ready);
endinterface

interface tgr_rsp_if;
   import tgr_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] row_x;
   logic [COORD_W-1:0] row_y;
   logic [BYTE_W-1:0]  row_mask;
   logic [COLOR_W-1:0] pixel_color;
   logic               last;

   modport source (output valid, row_x, row_y, row_mask, pixel_color, last,
                   input ready);
   modport sink   (input valid, row_x, row_y, row_mask, pixel_color, last,
                   output ready);
endinterface

FILE: rtl/text_glyph_renderer.sv
// text_glyph_renderer: 8-pixel-wide character generator with a text cursor
// depends on tgr_pkg, tgr_req_if and tgr_rsp_if
// flow: a taken print word loads the print context; font rows then go through the read
//   and output registers, one row a cycle while the output is not stalled; a printable
//   character holds off new words until its GLYPH_ROWS rows are read; other words do not
// reset: cursor to 0, line_width to 1024, pipeline emptied; font memory not cleared

module text_glyph_renderer (
   input  logic                            clock,
   input  logic                            reset,
   tgr_req_if.sink                         req,
   tgr_rsp_if.source                       rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tgr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tgr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tgr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import tgr_pkg::*;

   logic [BYTE_W-1:0] font_mem [STORE_DEPTH];

   state_type          state_ff, state_in;
   logic [COORD_W-1:0] line_width_ff;
   logic [COORD_W-1:0] cur_x_ff, cur_x_in;
   logic [COORD_W-1:0] cur_y_ff, cur_y_in;

   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ADDR_W-1:0]  base_ff;
   logic [COORD_W-1:0] pr_x_ff;
   logic [COORD_W-1:0] pr_y_ff;
   logic [COLOR_W-1:0] pr_color_ff;

   logic [BYTE_W-1:0]  mem_q_ff;
   logic               s1_valid_ff;
   row_meta_type       s1_meta_ff;
   row_meta_type       rd_meta;

   logic               out_valid_ff;
   logic [BYTE_W-1:0]  out_mask_ff;
   row_meta_type       out_meta_ff;

   logic               accept;
   logic               do_print;
   logic               row_last;
   logic               out_free;
   logic               s1_free;
   logic               rd_en;
   logic               mem_we;
   logic [ADDR_W-1:0]  rd_addr;
   logic [COORD_W:0]   next_x;
   logic [COORD_W:0]   down_y;
   logic [COORD_W-1:0] line_y;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == LINE_WIDTH_ADDR) ? CSR_DATA_W'(line_width_ff) : '0;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign do_print  = accept && (req.cmd == CMD_PRINT) && (req.char_code != CH_NEWLINE)
                      && (req.char_code != CH_RETURN);
   assign mem_we    = accept && (req.cmd == CMD_LOAD)
                      && (32'(req.font_index) < 32'(STORE_DEPTH));

   assign row_last  = (row_ff == ROW_W'(GLYPH_ROWS - 1));
   assign out_free  = !out_valid_ff || rsp.ready;
   assign s1_free   = !s1_valid_ff || out_free;
   assign rd_en     = (state_ff == ST_RUN) && s1_free;
   assign rd_addr   = base_ff + ADDR_W'(row_ff);

   assign rd_meta.x     = pr_x_ff;
   assign rd_meta.y     = pr_y_ff + COORD_W'(row_ff);
   assign rd_meta.color = pr_color_ff;
   assign rd_meta.last  = row_last;

   // cursor moves
   assign next_x = {1'b0, cur_x_ff} + (COORD_W + 1)'(GLYPH_WIDTH);
   assign down_y = {1'b0, cur_y_ff} + (COORD_W + 1)'(GLYPH_ROWS);
   assign line_y = (down_y > {1'b0, Y_LIMIT}) ? Y_LIMIT : down_y[COORD_W-1:0];

   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      if (accept && (req.cmd == CMD_CURSOR)) begin
         cur_x_in = req.start_x;
         cur_y_in = (req.start_y > Y_LIMIT) ? Y_LIMIT : req.start_y;
      end else if (accept && (req.cmd == CMD_PRINT)) begin
         if (req.char_code == CH_NEWLINE) begin
            cur_y_in = line_y;
         end else if (req.char_code == CH_RETURN) begin
            cur_x_in = '0;
         end else if (next_x >= {1'b0, line_width_ff}) begin
            cur_x_in = '0;
            cur_y_in = line_y;
         end else begin
            cur_x_in = next_x[COORD_W-1:0];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      case (state_ff)
         ST_IDLE: begin
            row_in = '0;
            if (do_print) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (rd_en) begin
               row_in = row_ff + ROW_W'(1);
               if (row_last) begin
                  state_in = ST_IDLE;
                  row_in   = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            row_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_ff        <= '0;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         line_width_ff <= LINE_WIDTH_RESET;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            line_width_ff <= csr_pwdata[COORD_W-1:0];
         end
         if (rd_en) begin
            s1_valid_ff <= 1'b1;
         end else if (out_free) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_valid_ff && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // print context and pipeline data registers
   always_ff @(posedge clock) begin
      if (do_print) begin
         base_ff     <= ADDR_W'(req.char_code[CODE_W-1:0]) * ADDR_W'(GLYPH_ROWS);
         pr_x_ff     <= cur_x_ff;
         pr_y_ff     <= cur_y_ff;
         pr_color_ff <= req.color;
      end
      if (rd_en) begin
         s1_meta_ff <= rd_meta;
      end
      if (s1_valid_ff && out_free) begin
         out_mask_ff <= mem_q_ff;
         out_meta_ff <= s1_meta_ff;
      end
   end

   // font memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         font_mem[ADDR_W'(req.font_index)] <= req.font_byte;
      end
      if (rd_en) begin
         mem_q_ff <= font_mem[rd_addr];
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.row_x       = out_meta_ff.x;
   assign rsp.row_y       = out_meta_ff.y;
   assign rsp.row_mask    = out_mask_ff;
   assign rsp.pixel_color = out_meta_ff.color;
   assign rsp.last        = out_meta_ff.last;

endmodule

FILE: dv/text_glyph_renderer_tb.sv
`timescale 1ns / 1ps
// text_glyph_renderer_tb: self-checking bench for the text glyph renderer, with a
// scoreboard that predicts glyph row words from the command stream and line_width
// depends on tgr_pkg, tgr_req_if, tgr_rsp_if and text_glyph_renderer

module text_glyph_renderer_tb;
   import tgr_pkg::*;

   localparam logic [CMD_W-1:0]      CMD_UNUSED      = 2'd3;
   localparam int unsigned           CYCLE_LIMIT     = 200000;
   localparam int                    HOLD_CYCLES     = 400;
   localparam int                    PHASE_WORDS     = 86;
   localparam int                    SETTLE_CYCLES   = 20;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [BYTE_W-1:0]  mask;
      logic [COLOR_W-1:0] color;
      logic               last;
   } glyph_row_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [COORD_W-1:0] font_index;
      logic [BYTE_W-1:0]  font_byte;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [BYTE_W-1:0]  char_code;
      logic [COLOR_W-1:0] color;
   } command_type;

   class glyph_row_board;
      logic [COORD_W-1:0] line_width;
      logic [COORD_W-1:0] pen_x;
      logic [COORD_W-1:0] pen_y;
      logic [BYTE_W-1:0]  glyph_bytes [STORE_DEPTH];
      glyph_row_type      rows_due [$];
      int                 errors;

      function new();
         line_width = LINE_WIDTH_RESET;
         pen_x = '0;
         pen_y = '0;
         errors = 0;
         foreach (glyph_bytes[i]) glyph_bytes[i] = '0;
      endfunction

      function logic [COORD_W-1:0] clamp_row(input logic [COORD_W:0] y);
         return (y > {1'b0, Y_LIMIT}) ? Y_LIMIT : y[COORD_W-1:0];
      endfunction

      function void take_command(input command_type w);
         glyph_row_type     row;
         logic [COORD_W:0]  next_x;
         logic [ADDR_W-1:0] base;
         case (w.cmd)
            CMD_LOAD: glyph_bytes[w.font_index] = w.font_byte;
            CMD_CURSOR: begin
               pen_x = w.start_x;
               pen_y = clamp_row({1'b0, w.start_y});
            end
            CMD_PRINT: begin
               if (w.char_code == CH_NEWLINE) begin
                  pen_y = clamp_row({1'b0, pen_y} + (COORD_W+1)'(GLYPH_ROWS));
               end else if (w.char_code == CH_RETURN) begin
                  pen_x = '0;
               end else begin
                  base = ADDR_W'(w.char_code) * ADDR_W'(GLYPH_ROWS);
                  for (int r = 0; r < GLYPH_ROWS; r++) begin
                     row.x = pen_x;
                     row.y = pen_y + COORD_W'(r);
                     row.mask = glyph_bytes[base + ADDR_W'(r)];
                     row.color = w.color;
                     row.last = (r == GLYPH_ROWS - 1);
                     rows_due.push_back(row);
                  end
                  next_x = {1'b0, pen_x} + (COORD_W+1)'(GLYPH_WIDTH);
                  if (next_x >= {1'b0, line_width}) begin
                     pen_x = '0;
                     pen_y = clamp_row({1'b0, pen_y} + (COORD_W+1)'(GLYPH_ROWS));
                  end else begin
                     pen_x = next_x[COORD_W-1:0];
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(input string name, input longint unsigned want,
                                  input longint unsigned got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void match_row(input glyph_row_type got);
         glyph_row_type want;
         if (rows_due.size() == 0) begin
            $display("%0t: row word with none expected, actual x %0d y %0d mask %0h",
                     $time, got.x, got.y, got.mask);
            errors++;
            return;
         end
         want = rows_due.pop_front();
         compare_field("row_x", want.x, got.x);
         compare_field("row_y", want.y, got.y);
         compare_field("row_mask", want.mask, got.mask);
         compare_field("pixel_color", want.color, got.color);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tgr_req_if req_bus ();
   tgr_rsp_if rsp_bus ();

   glyph_row_board board;
   bit             steady;
   bit             hold_wanted;
   int             hold_left;
   int             words_sent;
   int unsigned    cycle_count;
   logic [BYTE_W-1:0] printable_codes [$];

   text_glyph_renderer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_bus.ready = 1'b0;
         hold_left--;
      end else if (hold_wanted) begin
         hold_wanted = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready = 1'b0;
      end else begin
         rsp_bus.ready = steady || ($urandom_range(0, 99) >= 15);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.match_row(glyph_row_type'({rsp_bus.row_x, rsp_bus.row_y, rsp_bus.row_mask,
                                          rsp_bus.pixel_color, rsp_bus.last}));
   end

   function command_type scrambled(input logic [CMD_W-1:0] op);
      command_type w;
      w.cmd = op;
      w.font_index = COORD_W'($urandom);
      w.font_byte = BYTE_W'($urandom);
      w.start_x = COORD_W'($urandom);
      w.start_y = COORD_W'($urandom);
      w.char_code = BYTE_W'($urandom);
      w.color = $urandom;
      return w;
   endfunction

   task automatic send_word(input command_type w);
      while (!steady && $urandom_range(0, 99) < 15) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.cmd = w.cmd;
      req_bus.font_index = w.font_index;
      req_bus.font_byte = w.font_byte;
      req_bus.start_x = w.start_x;
      req_bus.start_y = w.start_y;
      req_bus.char_code = w.char_code;
      req_bus.color = w.color;
      req_bus.valid = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.take_command(w);
      if (w.cmd != CMD_UNUSED) words_sent++;
      @(negedge clock);
   endtask

   task automatic load_glyph(input logic [BYTE_W-1:0] code, input bit patterned);
      command_type w;
      logic [BYTE_W-1:0] edge_bytes [6];
      edge_bytes = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55};
      for (int r = 0; r < GLYPH_ROWS; r++) begin
         w = scrambled(CMD_LOAD);
         w.font_index = COORD_W'(code) * COORD_W'(GLYPH_ROWS) + COORD_W'(r);
         if (patterned && r < 6) w.font_byte = edge_bytes[r];
         send_word(w);
      end
      if (code != CH_NEWLINE && code != CH_RETURN && !(code inside {printable_codes}))
         printable_codes.push_back(code);
   endtask

   task automatic place_cursor(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      command_type w;
      w = scrambled(CMD_CURSOR);
      w.start_x = x;
      w.start_y = y;
      send_word(w);
   endtask

   task automatic print_char(input logic [BYTE_W-1:0] code, input logic [COLOR_W-1:0] color);
      command_type w;
      w = scrambled(CMD_PRINT);
      w.char_code = code;
      w.color = color;
      send_word(w);
   endtask

   task automatic write_line_width(input logic [COORD_W-1:0] width);
      logic [CSR_DATA_W-1:0] readback;
      csr_paddr = LINE_WIDTH_ADDR;
      csr_pwdata = {$urandom} & ~CSR_DATA_W'({COORD_W{1'b1}}) | CSR_DATA_W'(width);
      csr_pwrite = 1'b1;
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.line_width = width;
      @(negedge clock);
      csr_pwrite = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      if (readback[COORD_W-1:0] !== width) begin
         $display("%0t: line_width readback mismatch, expected %0d actual %0d",
                  $time, width, readback[COORD_W-1:0]);
         board.errors++;
      end
   endtask

   task automatic run_directed();
      command_type w;
      load_glyph(8'hFF, 1'b1);
      place_cursor(12'd4095, 12'd0);
      print_char(8'hFF, 32'hFFFF_FFFF);
      place_cursor(12'd0, 12'd4095);
      print_char(8'hFF, 32'h0000_0000);
      print_char(CH_NEWLINE, $urandom);
      print_char(CH_RETURN, $urandom);
      w = scrambled(CMD_UNUSED);
      send_word(w);
      place_cursor(12'd4080, 12'd16);
      print_char(8'hFF, $urandom);
   endtask

   task automatic run_random(input int count);
      command_type w;
      int target;
      int pick;
      target = words_sent + count;
      while (words_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 12 || printable_codes.size() == 0) begin
            load_glyph(BYTE_W'($urandom), 1'b0);
         end else if (pick < 67) begin
            print_char(printable_codes[$urandom_range(0, printable_codes.size() - 1)],
                       $urandom);
         end else if (pick < 77) begin
            place_cursor(COORD_W'($urandom), COORD_W'($urandom));
         end else if (pick < 83) begin
            print_char(CH_NEWLINE, $urandom);
         end else if (pick < 88) begin
            print_char(CH_RETURN, $urandom);
         end else if (pick < 94) begin
            w = scrambled(CMD_UNUSED);
            send_word(w);
         end else begin
            w = scrambled(CMD_LOAD);
            send_word(w);
         end
      end
   endtask

   task automatic drain();
      req_bus.valid = 1'b0;
      while (board.rows_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [COORD_W-1:0] widths [5];
      board = new();
      widths = '{12'd4088, 12'd8, 12'd1024, 12'd136, COORD_W'($urandom_range(8, 4088))};
      reset = 1'b1;
      steady = 1'b0;
      hold_wanted = 1'b0;
      hold_left = 0;
      words_sent = 0;
      cycle_count = 0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_LOAD;
      req_bus.font_index = '0;
      req_bus.font_byte = '0;
      req_bus.start_x = '0;
      req_bus.start_y = '0;
      req_bus.char_code = '0;
      req_bus.color = '0;
      rsp_bus.ready = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < 5; phase++) begin
         steady = (phase == 3);
         write_line_width(widths[phase]);
         if (phase == 0) begin
            run_directed();
            load_glyph(8'h00, 1'b0);
         end
         // stall the row side while commands keep coming
         if (phase == 1) hold_wanted = 1'b1;
         run_random(PHASE_WORDS);
         drain();
      end

      if (board.errors == 0 && board.rows_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
